// ===== hdl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster package
// Shared types, register indexes, constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_TILE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_FOV_ANGLE  = 2'd1;
  localparam logic [1:0] CFG_PROJ_GAIN  = 2'd2;

  // Register reset values.
  localparam logic [3:0]  TILE_SIZE_RST = 4'd5;
  localparam logic [8:0]  FOV_ANGLE_RST = 9'd128;
  localparam logic [15:0] PROJ_GAIN_RST = 16'd3090;

  // Width of the shared divider.
  localparam int DIV_W = 40;

  // Shade is SHADE_NUM / (SHADE_BIAS + d*d).
  localparam logic [DIV_W-1:0] SHADE_NUM  = 40'd4177920000;
  localparam logic [DIV_W-1:0] SHADE_BIAS = 40'd16384000;
  localparam logic [15:0]      SAT16      = 16'hFFFF;

  // Kind of an accepted beat after classification.
  typedef enum logic {
    ITEM_TILE,
    ITEM_CAST
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [5:0]  tile_x;
    logic [5:0]  tile_y;
    logic        tile_wall;
    logic [15:0] player_x;
    logic [15:0] player_y;
    logic [9:0]  player_angle;
  } item_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RAY,
    S_TRIG,
    S_MARCH,
    S_DEPTH,
    S_SQUARE,
    S_HEIGHT,
    S_EMIT
  } back_state_t;

  // Which quotient the shared divider is producing.
  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_H,
    DIV_S
  } div_op_t;

  typedef logic [14:0] sin_tab_t [257];

  // Quarter-wave sine in Q1.14, built by an integer rotation recurrence.
  function automatic sin_tab_t build_sine();
    sin_tab_t tab;
    longint   prev;
    longint   cur;
    longint   nxt;
    longint   t;
    longint   c;
    int       n;
    tab[0] = 15'd0;
    prev = 0;
    cur  = 6588356;
    c    = 1073721611;
    for (n = 1; n <= 256; n++) begin
      t = (cur + 32768) >>> 16;
      tab[n] = (t > 16384) ? 15'd16384 : 15'(t);
      nxt = ((2 * c * cur + (64'sd1 <<< 29)) >>> 30) - prev;
      prev = cur;
      cur  = nxt;
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sine();

  // Sine of a 1024-unit angle, Q1.14 signed.
  function automatic logic signed [15:0] sin_lookup(input logic [9:0] idx);
    logic [7:0]  r;
    logic [8:0]  m;
    logic [14:0] v;
    r = idx[7:0];
    m = idx[8] ? (9'd256 - {1'b0, r}) : {1'b0, r};
    v = SIN_TAB[m];
    return idx[9] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/grid_ray_march_caster.sv =====
// ----------------------------------------------------------------------------
// Grid ray march caster
// One-bit wall map with a fixed-step ray marcher: tile writes update the map,
// a cast beat marches RAYS rays and gives depth, height and shade per ray.
// ----------------------------------------------------------------------------
//  Channel   Signals                                     Direction
//  in        in_valid/in_ready, action .. player_angle   beat in
//  out       out_valid/out_ready, ray_index .. last_ray  beat out, one per ray
//  cfg       cfg_we, cfg_index, cfg_data                 register write
//
//  After reset the map is cleared one cell at a time; no beat is accepted
//  then. A tile write is applied from the idle state. A cast divides the
//  player position by the tile size, then marches each ray, one read of the
//  single map port per step, using the shared divider for height and shade.
//  A two-entry queue lets input beats arrive while results are stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_march_caster #(
  parameter int RAYS       = 64,
  parameter int MAP_SIZE   = 64,
  parameter int MAX_STEPS  = 1024,
  parameter int ANGLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [5:0]  tile_x,
  input  wire logic [5:0]  tile_y,
  input  wire logic        tile_wall,
  input  wire logic [15:0] player_x,
  input  wire logic [15:0] player_y,
  input  wire logic [9:0]  player_angle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       ray_index,
  output logic             hit,
  output logic [15:0]      corrected_depth,
  output logic [15:0]      wall_height,
  output logic [7:0]       shade,
  output logic             last_ray,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [3:0]     tile_size;
  logic [8:0]     fov_angle;
  logic [15:0]    projection_gain;
  logic           q_valid, q_pop, clear_done;
  grc_pkg::item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size       <= grc_pkg::TILE_SIZE_RST;
      fov_angle       <= grc_pkg::FOV_ANGLE_RST;
      projection_gain <= grc_pkg::PROJ_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        grc_pkg::CFG_TILE_SIZE: tile_size       <= cfg_data[3:0];
        grc_pkg::CFG_FOV_ANGLE: fov_angle       <= cfg_data[8:0];
        grc_pkg::CFG_PROJ_GAIN: projection_gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  grc_front #(
    .MAP_SIZE (MAP_SIZE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .tile_wall    (tile_wall),
    .player_x     (player_x),
    .player_y     (player_y),
    .player_angle (player_angle),
    .clear_done   (clear_done),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  grc_back #(
    .RAYS       (RAYS),
    .MAP_SIZE   (MAP_SIZE),
    .MAX_STEPS  (MAX_STEPS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .clear_done      (clear_done),
    .tile_size       (tile_size),
    .fov_angle       (fov_angle),
    .projection_gain (projection_gain),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ray         (ray_index),
    .out_hit         (hit),
    .out_depth       (corrected_depth),
    .out_height      (wall_height),
    .out_shade       (shade),
    .out_last        (last_ray)
  );

endmodule

`default_nettype wire

// ===== hdl/grc_ram.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/grc_div.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_div #(
  parameter int W = 40
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // One trial subtraction of the shifted partial remainder.
  always_comb begin
    shifted = {remainder, quotient[W-1]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CW'(W);
        remainder <= '0;
        quotient  <= dividend;
        dvs       <= divisor;
      end else if (busy) begin
        if (!diff[W]) begin
          remainder <= diff[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b1};
        end else begin
          remainder <= shifted[W-1:0];
          quotient  <= {quotient[W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/grc_front.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster front end
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_front #(
  parameter int MAP_SIZE = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          action,
  input  wire logic [5:0]    tile_x,
  input  wire logic [5:0]    tile_y,
  input  wire logic          tile_wall,
  input  wire logic [15:0]   player_x,
  input  wire logic [15:0]   player_y,
  input  wire logic [9:0]    player_angle,
  input  wire logic          clear_done,
  output logic               q_valid,
  output grc_pkg::item_t     q_item,
  input  wire logic          q_pop
);

  grc_pkg::item_t qmem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           keep;
  grc_pkg::item_t item_in;

  // Classify the beat; a tile write outside the map is dropped.
  always_comb begin
    item_in.kind         = action ? grc_pkg::ITEM_CAST : grc_pkg::ITEM_TILE;
    item_in.tile_x       = tile_x;
    item_in.tile_y       = tile_y;
    item_in.tile_wall    = tile_wall;
    item_in.player_x     = player_x;
    item_in.player_y     = player_y;
    item_in.player_angle = player_angle;
    in_ready = clear_done && (count != 2'd2);
    accept   = in_valid && in_ready;
    keep     = action || (({3'b000, tile_x} < 9'(MAP_SIZE)) &&
                          ({3'b000, tile_y} < 9'(MAP_SIZE)));
    q_valid  = (count != 2'd0);
    q_item   = qmem[rd_ptr];
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      qmem[wr_ptr] <= item_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((accept && keep) ? 1 : 0) - 2'(q_pop ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/grc_back.sv =====
// ----------------------------------------------------------------------------
// Grid ray caster back end
// Owns the wall map, clears it after reset, applies tile writes and marches
// every ray of a cast frame, one map lookup per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grc_back #(
  parameter int RAYS       = 64,
  parameter int MAP_SIZE   = 64,
  parameter int MAX_STEPS  = 1024,
  parameter int ANGLE_BITS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  grc_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               clear_done,
  input  wire logic [3:0]    tile_size,
  input  wire logic [8:0]    fov_angle,
  input  wire logic [15:0]   projection_gain,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [5:0]         out_ray,
  output logic               out_hit,
  output logic [15:0]        out_depth,
  output logic [15:0]        out_height,
  output logic [7:0]         out_shade,
  output logic               out_last
);

  localparam int RIW     = $clog2(RAYS);
  localparam int KW      = $clog2(MAX_STEPS + 1);
  localparam int TB      = $clog2(MAP_SIZE);
  localparam int DEPTH   = MAP_SIZE * MAP_SIZE;
  localparam int AW      = $clog2(DEPTH);
  localparam int SH_DOWN = (ANGLE_BITS >= 10) ? ANGLE_BITS - 10 : 0;
  localparam int SH_UP   = (ANGLE_BITS >= 10) ? 0 : 10 - ANGLE_BITS;
  localparam int DW      = grc_pkg::DIV_W;
  // Reciprocal of RAYS in Q0.16; exact for every 9-bit field of view.
  localparam int RECIP   = (65536 + RAYS - 1) / RAYS;

  grc_pkg::back_state_t state, state_next;
  grc_pkg::div_op_t     div_op;
  grc_pkg::item_t       item;

  logic [AW-1:0]        clr_addr;
  logic signed [11:0]   qx, qy, tx, ty;
  logic signed [20:0]   r0x, r0y, rx, ry;
  logic [8:0]           fq, rq;
  logic [RIW:0]         fr, rr;
  logic [RIW-1:0]       ray;
  logic [9:0]           ang_idx, rel_idx;
  logic signed [15:0]   dc, ds, coff;
  logic [KW-1:0]        kc, pend_k, hit_k;
  logic                 pend, hit;
  logic [17:0]          dep;
  logic [35:0]          dsq;
  logic [15:0]          height;

  // Control and datapath signals.
  logic                 ram_we, ram_re, ram_wdata, ram_rdata;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic                 div_start, div_done;
  logic [DW-1:0]        div_a, div_b, div_q, div_r;
  logic [3:0]           ts_eff;
  logic signed [20:0]   span, nrx, nry;
  logic signed [10:0]   rel;
  logic [15:0]          ang_sum;
  logic                 oob, pend_hit, steps_out, emit_go, last;
  logic [RIW:0]         rr_sum;
  logic signed [KW+16:0] prod;
  logic [8:0]           fq_c;
  logic [RIW:0]         fr_c;

  // Map the low ANGLE_BITS of an angle onto the 1024-unit table.
  function automatic logic [9:0] to_idx(input logic [15:0] a);
    logic [31:0] m;
    m = 32'(a) & ((32'd1 << ANGLE_BITS) - 32'd1);
    return 10'((m >> SH_DOWN) << SH_UP);
  endfunction

  // Tile address of a map cell.
  function automatic logic [AW-1:0] tile_addr(input logic [TB-1:0] x,
                                              input logic [TB-1:0] y);
    return AW'(32'(x) * MAP_SIZE + 32'(y));
  endfunction

  grc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grc_div #(
    .W (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Geometry helpers for the current ray and march step.
  always_comb begin
    ts_eff  = (tile_size == 4'd0) ? 4'd1 : tile_size;
    span    = $signed({2'b00, ts_eff, 15'd0});
    rel     = $signed({2'b00, rq}) - $signed({3'b000, fov_angle[8:1]});
    ang_sum = {6'd0, item.player_angle} + 16'(rel);
    nrx     = rx + 21'(dc);
    nry     = ry + 21'(ds);
    oob     = (tx < 12'sd0) || (ty < 12'sd0) ||
              (tx >= $signed(12'(MAP_SIZE))) || (ty >= $signed(12'(MAP_SIZE)));
    pend_hit  = pend && ram_rdata;
    steps_out = (kc == KW'(MAX_STEPS));
    emit_go   = !out_valid || out_ready;
    last      = (ray == RIW'(RAYS - 1));
    rr_sum    = rr + fr;
    prod      = $signed({1'b0, hit_k}) * coff;
    clear_done = (state != grc_pkg::S_CLEAR);
    // Per-ray angle step: quotient and remainder of fov_angle by RAYS.
    fq_c = 9'((32'(fov_angle) * 32'(RECIP)) >> 16);
    fr_c = (RIW + 1)'(32'(fov_angle) - 32'(fq_c) * 32'(RAYS));
  end

  // Next state and control outputs.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = tile_addr(tx[TB-1:0], ty[TB-1:0]);
    div_start  = 1'b0;
    div_a      = DW'(q_item.player_x[15:6]);
    div_b      = DW'(ts_eff);
    unique case (state)
      grc_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = grc_pkg::S_IDLE;
        end
      end
      grc_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == grc_pkg::ITEM_TILE) begin
            ram_we    = 1'b1;
            ram_waddr = tile_addr(TB'(q_item.tile_x), TB'(q_item.tile_y));
            ram_wdata = q_item.tile_wall;
          end else begin
            div_start  = 1'b1;
            state_next = grc_pkg::S_DIV;
          end
        end
      end
      grc_pkg::S_DIV: begin
        if (div_done) begin
          unique case (div_op)
            grc_pkg::DIV_X: begin
              div_start = 1'b1;
              div_a     = DW'(item.player_y[15:6]);
            end
            grc_pkg::DIV_Y: begin
              state_next = grc_pkg::S_RAY;
            end
            grc_pkg::DIV_H: begin
              div_start = 1'b1;
              div_a     = grc_pkg::SHADE_NUM;
              div_b     = grc_pkg::SHADE_BIAS + DW'(dsq);
            end
            grc_pkg::DIV_S: begin
              state_next = grc_pkg::S_EMIT;
            end
            default: begin
              state_next = grc_pkg::S_IDLE;
            end
          endcase
        end
      end
      grc_pkg::S_RAY: begin
        state_next = grc_pkg::S_TRIG;
      end
      grc_pkg::S_TRIG: begin
        state_next = grc_pkg::S_MARCH;
      end
      grc_pkg::S_MARCH: begin
        if (pend_hit) begin
          state_next = grc_pkg::S_DEPTH;
        end else if (steps_out) begin
          state_next = grc_pkg::S_EMIT;
        end else if (oob) begin
          state_next = grc_pkg::S_DEPTH;
        end else begin
          ram_re = 1'b1;
        end
      end
      grc_pkg::S_DEPTH: begin
        state_next = grc_pkg::S_SQUARE;
      end
      grc_pkg::S_SQUARE: begin
        state_next = grc_pkg::S_HEIGHT;
      end
      grc_pkg::S_HEIGHT: begin
        div_start  = 1'b1;
        state_next = grc_pkg::S_DIV;
        if (dep == 18'd0) begin
          div_a = grc_pkg::SHADE_NUM;
          div_b = grc_pkg::SHADE_BIAS + DW'(dsq);
        end else begin
          div_a = DW'({projection_gain, 7'd0});
          div_b = DW'(dep);
        end
      end
      grc_pkg::S_EMIT: begin
        if (emit_go) begin
          state_next = last ? grc_pkg::S_IDLE : grc_pkg::S_RAY;
        end
      end
      default: begin
        state_next = grc_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (state == grc_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == grc_pkg::S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end
      if (state == grc_pkg::S_RAY) begin
        pend <= 1'b0;
      end else if (state == grc_pkg::S_MARCH) begin
        pend <= ram_re;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      grc_pkg::S_IDLE: begin
        if (q_valid && q_item.kind == grc_pkg::ITEM_CAST) begin
          item   <= q_item;
          div_op <= grc_pkg::DIV_X;
        end
      end
      grc_pkg::S_DIV: begin
        if (div_done) begin
          case (div_op)
            grc_pkg::DIV_X: begin
              qx     <= $signed({2'b00, div_q[9:0]});
              r0x    <= $signed({2'b00, div_r[3:0], item.player_x[5:0], 9'd0});
              div_op <= grc_pkg::DIV_Y;
            end
            grc_pkg::DIV_Y: begin
              qy  <= $signed({2'b00, div_q[9:0]});
              r0y <= $signed({2'b00, div_r[3:0], item.player_y[5:0], 9'd0});
              fq  <= fq_c;
              fr  <= fr_c;
              rq  <= 9'd0;
              rr  <= '0;
              ray <= '0;
            end
            grc_pkg::DIV_H: begin
              height <= (div_q > DW'(grc_pkg::SAT16)) ? grc_pkg::SAT16 : div_q[15:0];
              div_op <= grc_pkg::DIV_S;
            end
            default: begin
            end
          endcase
        end
      end
      grc_pkg::S_RAY: begin
        ang_idx <= to_idx(ang_sum);
        rel_idx <= to_idx(16'(rel));
        tx <= qx;
        ty <= qy;
        rx <= r0x;
        ry <= r0y;
        kc <= '0;
      end
      grc_pkg::S_TRIG: begin
        dc   <= grc_pkg::sin_lookup(ang_idx + 10'd256);
        ds   <= grc_pkg::sin_lookup(ang_idx);
        coff <= grc_pkg::sin_lookup(rel_idx + 10'd256);
      end
      grc_pkg::S_MARCH: begin
        if (pend_hit) begin
          hit   <= 1'b1;
          hit_k <= pend_k;
        end else if (steps_out) begin
          hit <= 1'b0;
        end else if (oob) begin
          hit   <= 1'b1;
          hit_k <= kc;
        end else begin
          // Step to the next point, moving at most one tile per axis.
          pend_k <= kc;
          kc     <= kc + KW'(1);
          if (nrx >= span) begin
            rx <= nrx - span;
            tx <= tx + 12'sd1;
          end else if (nrx < 21'sd0) begin
            rx <= nrx + span;
            tx <= tx - 12'sd1;
          end else begin
            rx <= nrx;
          end
          if (nry >= span) begin
            ry <= nry - span;
            ty <= ty + 12'sd1;
          end else if (nry < 21'sd0) begin
            ry <= nry + span;
            ty <= ty - 12'sd1;
          end else begin
            ry <= nry;
          end
        end
      end
      grc_pkg::S_DEPTH: begin
        dep <= (prod < 0) ? 18'd0 : 18'(prod >>> 8);
      end
      grc_pkg::S_SQUARE: begin
        dsq <= dep * dep;
      end
      grc_pkg::S_HEIGHT: begin
        if (dep == 18'd0) begin
          height <= grc_pkg::SAT16;
          div_op <= grc_pkg::DIV_S;
        end else begin
          div_op <= grc_pkg::DIV_H;
        end
      end
      grc_pkg::S_EMIT: begin
        if (emit_go) begin
          out_ray    <= 6'(ray);
          out_last   <= last;
          out_hit    <= hit;
          out_depth  <= hit ? ((dep > 18'(grc_pkg::SAT16)) ? grc_pkg::SAT16 : dep[15:0])
                            : 16'd0;
          out_height <= hit ? height : 16'd0;
          out_shade  <= hit ? div_q[7:0] : 8'd0;
          ray        <= ray + RIW'(1);
          // Advance floor(i*fov/RAYS) by quotient and remainder.
          if (rr_sum >= (RIW + 1)'(RAYS)) begin
            rr <= rr_sum - (RIW + 1)'(RAYS);
            rq <= rq + fq + 9'd1;
          end else begin
            rr <= rr_sum;
            rq <= rq + fq;
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // A ray with no wall carries no distance, height or shade.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_depth == 16'd0 && out_height == 16'd0 &&
                              out_shade == 8'd0)
    else $error("miss beat carries nonzero fields");

  // A hit at zero depth saturates the height and gives full shade.
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_hit && out_depth == 16'd0 |->
      out_height == grc_pkg::SAT16 && out_shade == 8'd255)
    else $error("zero depth hit not saturated");

  // The map is neither read nor popped while it is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == grc_pkg::S_CLEAR |-> !q_pop && !ram_re)
    else $error("activity during clearing pass");

  // The final ray flag marks the last ray number only.
  a_last_ray: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_ray == 6'(RAYS - 1))
    else $error("last ray flag on wrong ray");
`endif

endmodule

`default_nettype wire

// ===== tb/grid_ray_march_caster_tb.sv =====
// ----------------------------------------------------------------------------
// Grid ray march caster testbench
// Drives tile writes and cast beats through the valid/ready input channel,
// predicts every ray result with a local copy of the wall map, trig table and
// registers, and compares each output beat field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_ray_march_caster_tb;

  localparam int NUM_RAYS   = 64;
  localparam int GRID       = 64;
  localparam int STEP_LIMIT = 1024;
  localparam int WATCHDOG   = 40000;
  localparam int SETTLE     = 300;
  // Index past the last register; writes to it must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    grc_pkg::item_kind_t kind;
    logic [5:0]          tile_x;
    logic [5:0]          tile_y;
    logic                tile_wall;
    logic [15:0]         player_x;
    logic [15:0]         player_y;
    logic [9:0]          player_angle;
  } beat_t;

  typedef struct {
    logic [5:0]  ray_index;
    logic        hit;
    logic [15:0] depth;
    logic [15:0] height;
    logic [7:0]  shade;
    logic        last_ray;
  } ray_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [5:0]  tile_x;
  logic [5:0]  tile_y;
  logic        tile_wall;
  logic [15:0] player_x;
  logic [15:0] player_y;
  logic [9:0]  player_angle;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  ray_index;
  logic        hit;
  logic [15:0] corrected_depth;
  logic [15:0] wall_height;
  logic [7:0]  shade;
  logic        last_ray;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  grid_ray_march_caster dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .tile_x(tile_x), .tile_y(tile_y), .tile_wall(tile_wall),
    .player_x(player_x), .player_y(player_y), .player_angle(player_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .ray_index(ray_index), .hit(hit), .corrected_depth(corrected_depth),
    .wall_height(wall_height), .shade(shade), .last_ray(last_ray),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copies of the block state.
  bit          wall_grid [GRID][GRID];
  logic [3:0]  tile_span_reg;
  logic [8:0]  fov_reg;
  logic [15:0] gain_reg;
  longint      sine_q14 [257];

  beat_t       pending_beats[$];
  ray_result_t expected_rays[$];
  beat_t       cur_beat;
  int          mismatches;
  int          rays_checked;
  int          casts_sent;
  int          tiles_sent;
  int          cycle_count;
  int          quiet_cycles;

  // Quarter-wave sine in Q1.14 from the integer rotation recurrence.
  function automatic void make_sine_table();
    longint prev;
    longint cur;
    longint nxt;
    longint t;
    prev = 0;
    cur = 6588356;
    sine_q14[0] = 0;
    for (int n = 1; n <= 256; n++) begin
      t = (cur + 32768) >>> 16;
      sine_q14[n] = (t > 16384) ? 16384 : t;
      nxt = ((2 * 64'sd1073721611 * cur + (64'sd1 <<< 29)) >>> 30) - prev;
      prev = cur;
      cur = nxt;
    end
  endfunction

  function automatic longint sine_of(int unsigned a);
    int unsigned r;
    int unsigned q;
    longint v;
    r = a & 255;
    q = (a >> 8) & 3;
    v = q[0] ? sine_q14[256 - r] : sine_q14[r];
    return q[1] ? -v : v;
  endfunction

  function automatic bit blocked(longint x, longint y);
    longint span;
    longint tx;
    longint ty;
    if (x < 0 || y < 0) return 1'b1;
    span = longint'((tile_span_reg == 0) ? 1 : tile_span_reg) << 15;
    tx = x / span;
    ty = y / span;
    if (tx >= GRID || ty >= GRID) return 1'b1;
    return wall_grid[tx][ty];
  endfunction

  // Apply one accepted beat: update the map or queue one result per ray.
  task automatic march_rays(input beat_t b);
    longint px;
    longint py;
    longint dc;
    longint ds;
    longint coff;
    longint prod;
    longint depth_raw;
    longint hgt;
    int rel;
    int unsigned ang;
    int k;
    ray_result_t r;
    if (b.kind == grc_pkg::ITEM_TILE) begin
      wall_grid[b.tile_x][b.tile_y] = b.tile_wall;
      tiles_sent++;
    end else begin
      casts_sent++;
      px = longint'(b.player_x) * 512;
      py = longint'(b.player_y) * 512;
      for (int i = 0; i < NUM_RAYS; i++) begin
        rel = (i * int'(fov_reg)) / NUM_RAYS - int'(fov_reg >> 1);
        ang = (int'(b.player_angle) + rel) & 1023;
        dc = sine_of(ang + 256);
        ds = sine_of(ang);
        coff = sine_of((rel & 1023) + 256);
        for (k = 0; k < STEP_LIMIT; k++) begin
          if (blocked(px + dc * k, py + ds * k)) break;
        end
        r.ray_index = i[5:0];
        r.last_ray = (i == NUM_RAYS - 1);
        if (k == STEP_LIMIT) begin
          r.hit = 1'b0;
          r.depth = '0;
          r.height = '0;
          r.shade = '0;
        end else begin
          prod = longint'(k) * coff;
          depth_raw = (prod < 0) ? 0 : (prod >>> 8);
          r.hit = 1'b1;
          r.depth = (depth_raw > 65535) ? 16'hFFFF : depth_raw[15:0];
          if (depth_raw == 0) hgt = 65535;
          else hgt = (longint'(gain_reg) * 128) / depth_raw;
          r.height = (hgt > 65535) ? 16'hFFFF : hgt[15:0];
          r.shade = 8'(64'd4177920000 / (64'd16384000 + depth_raw * depth_raw));
        end
        expected_rays.push_back(r);
      end
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random idling, with a long stretch that never idles.
  function automatic bit take_break();
    if (cycle_count > 30000 && cycle_count < 120000) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // Input driver: presents queued beats and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) march_rays(cur_beat);
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && !take_break()) begin
          cur_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          action <= (cur_beat.kind == grc_pkg::ITEM_CAST);
          tile_x <= cur_beat.tile_x;
          tile_y <= cur_beat.tile_y;
          tile_wall <= cur_beat.tile_wall;
          player_x <= cur_beat.player_x;
          player_y <= cur_beat.player_y;
          player_angle <= cur_beat.player_angle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each ray beat with the oldest prediction.
  always @(posedge clk) begin
    ray_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
      if (out_valid && out_ready) begin
        rays_checked++;
        if (expected_rays.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected ray beat, ray %0d", ray_index);
        end else begin
          want = expected_rays.pop_front();
          if (ray_index !== want.ray_index || hit !== want.hit ||
              corrected_depth !== want.depth || wall_height !== want.height ||
              shade !== want.shade || last_ray !== want.last_ray) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Ray mismatch: exp idx %0d hit %0d d %0d h %0d sh %0d last %0d, got %0d %0d %0d %0d %0d %0d",
                       want.ray_index, want.hit, want.depth, want.height, want.shade,
                       want.last_ray, ray_index, hit, corrected_depth, wall_height,
                       shade, last_ray);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_tile(input int x, input int y, input bit w);
    beat_t b;
    b.kind = grc_pkg::ITEM_TILE;
    b.tile_x = x[5:0];
    b.tile_y = y[5:0];
    b.tile_wall = w;
    b.player_x = 16'($urandom);
    b.player_y = 16'($urandom);
    b.player_angle = 10'($urandom);
    pending_beats.push_back(b);
  endtask

  task automatic add_cast(input int x, input int y, input int a);
    beat_t b;
    b.kind = grc_pkg::ITEM_CAST;
    b.tile_x = 6'($urandom);
    b.tile_y = 6'($urandom);
    b.tile_wall = 1'($urandom);
    b.player_x = x[15:0];
    b.player_y = y[15:0];
    b.player_angle = a[9:0];
    pending_beats.push_back(b);
  endtask

  // Wait until everything is sent and answered, then let the block settle.
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_rays.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      grc_pkg::CFG_TILE_SIZE: tile_span_reg = val[3:0];
      grc_pkg::CFG_FOV_ANGLE: fov_reg = val[8:0];
      grc_pkg::CFG_PROJ_GAIN: gain_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly walls near a focus tile and casts from inside it; some noise.
  task automatic random_round(input int count);
    int fx;
    int fy;
    int ppt;
    fx = $urandom_range(GRID - 1);
    fy = $urandom_range(GRID - 1);
    ppt = ((tile_span_reg == 0) ? 1 : int'(tile_span_reg)) * 64;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 55) begin
        add_tile((fx + $urandom_range(6) - 3) & 63, (fy + $urandom_range(6) - 3) & 63,
                 $urandom_range(99) < 75);
      end else if ($urandom_range(99) < 85) begin
        add_cast(((fx * ppt + $urandom_range(ppt - 1)) > 65535) ? 65535 :
                 fx * ppt + $urandom_range(ppt - 1),
                 ((fy * ppt + $urandom_range(ppt - 1)) > 65535) ? 65535 :
                 fy * ppt + $urandom_range(ppt - 1),
                 $urandom_range(1023));
      end else begin
        add_cast($urandom_range(65535), $urandom_range(65535), $urandom_range(1023));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    action = 1'b0;
    tile_x = '0;
    tile_y = '0;
    tile_wall = 1'b0;
    player_x = '0;
    player_y = '0;
    player_angle = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    rays_checked = 0;
    casts_sent = 0;
    tiles_sent = 0;
    cycle_count = 0;
    quiet_cycles = 0;
    tile_span_reg = grc_pkg::TILE_SIZE_RST;
    fov_reg = grc_pkg::FOV_ANGLE_RST;
    gain_reg = grc_pkg::PROJ_GAIN_RST;
    make_sine_table();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: map corners, set and clear, origin and far-corner casts,
    // zero depth from inside a wall, headings at both ends of the range.
    add_tile(0, 0, 1'b1);
    add_tile(63, 63, 1'b1);
    add_tile(63, 0, 1'b1);
    add_tile(0, 63, 1'b0);
    add_cast(0, 0, 0);
    add_tile(0, 0, 1'b0);
    add_tile(2, 1, 1'b1);
    add_tile(1, 2, 1'b1);
    add_cast(16, 16, 1023);
    add_cast(65535, 65535, 512);
    add_tile(63, 63, 1'b0);
    add_tile(42, 21, 1'b1);
    add_cast(100, 60, 256);
    add_cast(320, 320, 768);
    drain();

    // Narrowest view, zero gain, smallest tiles.
    write_reg(grc_pkg::CFG_TILE_SIZE, 16'd1);
    write_reg(grc_pkg::CFG_FOV_ANGLE, 16'd1);
    write_reg(grc_pkg::CFG_PROJ_GAIN, 16'd0);
    random_round(30);
    drain();

    // Widest view, largest gain and tiles; a write past the last register.
    write_reg(grc_pkg::CFG_TILE_SIZE, 16'd15);
    write_reg(grc_pkg::CFG_FOV_ANGLE, 16'd511);
    write_reg(grc_pkg::CFG_PROJ_GAIN, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'hFFFF);
    add_tile(1, 0, 1'b1);
    add_tile(1, 1, 1'b1);
    add_tile(0, 1, 1'b1);
    add_cast(600, 600, $urandom_range(1023));
    add_cast(61439, 900, 300);
    drain();

    // Tile size zero behaves as one.
    write_reg(grc_pkg::CFG_TILE_SIZE, 16'd0);
    write_reg(grc_pkg::CFG_FOV_ANGLE, 16'($urandom_range(1, 511)));
    write_reg(grc_pkg::CFG_PROJ_GAIN, 16'($urandom));
    random_round(30);
    drain();

    write_reg(grc_pkg::CFG_TILE_SIZE, 16'd2);
    write_reg(grc_pkg::CFG_FOV_ANGLE, 16'($urandom_range(1, 511)));
    write_reg(grc_pkg::CFG_PROJ_GAIN, 16'($urandom));
    random_round(25);
    drain();

    $display("Sent %0d tile writes and %0d casts; checked %0d ray beats.",
             tiles_sent, casts_sent, rays_checked);
    $display("Covered default, minimum, maximum and zero tile-size settings.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
